>>> src/sce_pkg.sv
// Shared constants and types for the seam cumulative energy block.
`default_nettype none
package sce_pkg;

	localparam int ENERGY_W = 16;
	localparam int RESULT_W = 32;
	localparam int IMAGE_WIDTH_W = 12;
	localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RESET = 12'd2048;
	localparam logic [RESULT_W-1:0] SAT_VALUE = 32'hFFFF_FFFF;

	// Per-pixel control carried from the column tracker into the arithmetic stage.
	typedef struct packed {
		logic first_row;
		logic row_last;
		logic has_left;
		logic has_right;
		logic fwd_upper;
		logic fwd_upper_right;
	} sce_flags_t;

endpackage
`default_nettype wire

>>> src/sce_if.sv
// Channel interfaces for pixel input, result output and configuration writes.
`default_nettype none
interface sce_pix_if;
	import sce_pkg::*;
	logic                valid;
	logic                ready;
	logic [ENERGY_W-1:0] pixel_energy;
	logic                frame_start;
	modport source (output valid, output pixel_energy, output frame_start, input ready);
	modport sink (input valid, input pixel_energy, input frame_start, output ready);
endinterface

interface sce_res_if;
	import sce_pkg::*;
	logic                valid;
	logic                ready;
	logic [RESULT_W-1:0] cumulative_energy;
	logic                row_last;
	modport source (output valid, output cumulative_energy, output row_last, input ready);
	modport sink (input valid, input cumulative_energy, input row_last, output ready);
endinterface

interface sce_cfg_if;
	import sce_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [IMAGE_WIDTH_W-1:0] image_width;
	modport source (output valid, output image_width, input ready);
	modport sink (input valid, input image_width, output ready);
endinterface
`default_nettype wire

>>> src/seam_cumulative_energy.sv
// Top level of the streaming vertical seam cumulative energy block.
// A pixel is registered into stage one as its line buffer read is issued, and its result
// then into the output register, which holds it until the sink takes it.
// Throughput: one pixel per cycle unless the sink stalls, limited by one access per port.
// Reset clears the column counter and held left value, sets the first-row flag, and
// loads 2048 into the width register; the line buffer has no reset.
`default_nettype none
module seam_cumulative_energy #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire     clk,
	input  wire     arst_n,
	sce_pix_if.sink   pixel_in,
	sce_res_if.source seam_out,
	sce_cfg_if.sink   cfg
);
	import sce_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = AW + 1;
	localparam int CW = (WW > IMAGE_WIDTH_W) ? WW : IMAGE_WIDTH_W;

	// Config register, always ready; the host must write only while idle (not enforced).
	logic [IMAGE_WIDTH_W-1:0] width_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= IMAGE_WIDTH_RESET;
		end else if (cfg.valid) begin
			width_q <= cfg.image_width;
		end
	end

	// The effective width folds a zero width to one and clamps at the buffer depth.
	logic [CW-1:0] width_ext;
	logic [WW-1:0] eff_width;

	always_comb begin
		width_ext = CW'(width_q);
		if (width_ext == '0) begin
			eff_width = WW'(1);
		end else if (width_ext > CW'(MAX_WIDTH)) begin
			eff_width = WW'(MAX_WIDTH);
		end else begin
			eff_width = WW'(width_ext);
		end
	end

	// Pipeline handshake. Stage one holds the pixel while the line buffer read
	// completes; the output register parts it from the downstream sink, so a new
	// pixel is taken whenever stage one is empty or moving on.
	logic valid_s1;
	logic out_valid_q;
	logic s1_fire;
	logic accept;

	assign s1_fire        = valid_s1 && (!out_valid_q || seam_out.ready);
	assign pixel_in.ready = !valid_s1 || s1_fire;
	assign accept         = pixel_in.valid && pixel_in.ready;

	// Column tracking at acceptance. A frame start restarts the first row; a
	// column at or past a shrunken width wraps to a new row that is not the first.
	logic [AW-1:0] col_q;
	logic          first_q;
	logic [AW-1:0] col;
	logic          first_row;
	logic [WW-1:0] col_plus1;
	logic          last;
	sce_flags_t    flags;

	logic [AW-1:0]       col_s1;
	logic [ENERGY_W-1:0] energy_s1;
	sce_flags_t          flags_s1;
	logic [RESULT_W-1:0] fwd_data_s1;
	logic [RESULT_W-1:0] held_q;
	logic [RESULT_W-1:0] upper;
	logic [RESULT_W-1:0] result;

	always_comb begin
		if (pixel_in.frame_start) begin
			col       = '0;
			first_row = 1'b1;
		end else if ({1'b0, col_q} >= eff_width) begin
			col       = '0;
			first_row = 1'b0;
		end else begin
			col       = col_q;
			first_row = first_q;
		end
		col_plus1 = {1'b0, col} + WW'(1);
		last      = (col_plus1 == eff_width);

		flags.first_row = first_row;
		flags.row_last  = last;
		flags.has_left  = (col != '0);
		flags.has_right = (col_plus1 < eff_width);
		// The pixel leaving stage one in this same cycle writes the buffer too
		// late for this read, so its result is forwarded instead.
		flags.fwd_upper       = s1_fire && (col_s1 == col);
		flags.fwd_upper_right = s1_fire && (col_s1 == col_plus1[AW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			col_q   <= last ? '0 : col_plus1[AW-1:0];
			first_q <= last ? 1'b0 : first_row;
		end
	end

	// Stage one registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_in.ready) begin
			valid_s1 <= pixel_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col;
			energy_s1   <= pixel_in.pixel_energy;
			flags_s1    <= flags;
			fwd_data_s1 <= result;
		end
	end

	// Line buffer: the upper and upper-right neighbors are read at acceptance,
	// and each result overwrites its own column as it leaves stage one.
	logic [RESULT_W-1:0] rd_upper;
	logic [RESULT_W-1:0] rd_upper_right;

	sce_line_ram #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_ram (
		.clk     (clk),
		.we      (s1_fire),
		.waddr   (col_s1),
		.wdata   (result),
		.re      (accept),
		.raddr_a (col),
		.raddr_b (col_plus1[AW-1:0]),
		.rdata_a (rd_upper),
		.rdata_b (rd_upper_right)
	);

	sce_min_add u_min_add (
		.flags          (flags_s1),
		.energy         (energy_s1),
		.rd_upper       (rd_upper),
		.rd_upper_right (rd_upper_right),
		.fwd_data       (fwd_data_s1),
		.held_left      (held_q),
		.upper          (upper),
		.result         (result)
	);

	// The held value is the previous pixel's upper neighbor, which its own
	// write has already replaced in the buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (s1_fire) begin
			held_q <= upper;
		end
	end

	// Output register.
	logic [RESULT_W-1:0] out_energy_q;
	logic                out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (seam_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_energy_q <= result;
			out_last_q   <= flags_s1.row_last;
		end
	end

	assign seam_out.valid             = out_valid_q;
	assign seam_out.cumulative_energy = out_energy_q;
	assign seam_out.row_last          = out_last_q;

endmodule
`default_nettype wire

>>> src/sce_line_ram.sv
// Previous-row line buffer: one write port and two registered read ports.
`default_nettype none
module sce_line_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  wire                        clk,
	input  wire                        we,
	input  wire [AW-1:0]               waddr,
	input  wire [sce_pkg::RESULT_W-1:0] wdata,
	input  wire                        re,
	input  wire [AW-1:0]               raddr_a,
	input  wire [AW-1:0]               raddr_b,
	output logic [sce_pkg::RESULT_W-1:0] rdata_a,
	output logic [sce_pkg::RESULT_W-1:0] rdata_b
);
	import sce_pkg::*;

	logic [RESULT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Reads return the contents from before a same-cycle write.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

>>> src/sce_min_add.sv
// Neighbor minimum and saturating accumulate for one pixel.
`default_nettype none
module sce_min_add (
	input  wire sce_pkg::sce_flags_t        flags,
	input  wire [sce_pkg::ENERGY_W-1:0]     energy,
	input  wire [sce_pkg::RESULT_W-1:0]     rd_upper,
	input  wire [sce_pkg::RESULT_W-1:0]     rd_upper_right,
	input  wire [sce_pkg::RESULT_W-1:0]     fwd_data,
	input  wire [sce_pkg::RESULT_W-1:0]     held_left,
	output logic [sce_pkg::RESULT_W-1:0]    upper,
	output logic [sce_pkg::RESULT_W-1:0]    result
);
	import sce_pkg::*;

	logic [RESULT_W-1:0] upper_right;
	logic [RESULT_W-1:0] best;
	logic [RESULT_W:0]   sum;

	always_comb begin
		upper       = flags.fwd_upper ? fwd_data : rd_upper;
		upper_right = flags.fwd_upper_right ? fwd_data : rd_upper_right;
		best        = upper;
		if (flags.has_left && (held_left < best)) begin
			best = held_left;
		end
		if (flags.has_right && (upper_right < best)) begin
			best = upper_right;
		end
		sum = {1'b0, best} + (RESULT_W + 1)'(energy);
		if (flags.first_row) begin
			result = RESULT_W'(energy);
		end else if (sum[RESULT_W]) begin
			result = SAT_VALUE;
		end else begin
			result = sum[RESULT_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> src/sce_checker.sv
// Port-level assertions for the seam cumulative energy block and their binding.
`default_nettype none
module sce_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         pix_valid,
	input wire                         pix_ready,
	input wire                         res_valid,
	input wire                         res_ready,
	input wire [sce_pkg::RESULT_W-1:0] res_energy,
	input wire                         res_last,
	input wire                         cfg_valid,
	input wire                         cfg_ready
);
	import sce_pkg::*;

	// Transactions accepted but not yet delivered.
	logic [1:0] pending_q;
	logic       pix_acc;
	logic       res_acc;

	assign pix_acc = pix_valid && pix_ready;
	assign res_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(pix_acc) - 2'(res_acc);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_energy) && $stable(res_last))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 2'd0)
		else $error("result offered with no pixel in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc |-> (pending_q < 2'd2) || res_acc)
		else $error("pixel accepted beyond pipeline capacity");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd0 |-> pix_ready)
		else $error("input not ready while empty");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind seam_cumulative_energy sce_checker u_sce_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pixel_in.valid),
	.pix_ready  (pixel_in.ready),
	.res_valid  (seam_out.valid),
	.res_ready  (seam_out.ready),
	.res_energy (seam_out.cumulative_energy),
	.res_last   (seam_out.row_last),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready)
);
`default_nettype wire

>>> test/tb_seam_cumulative_energy.sv
// Self-checking testbench for the streaming seam cumulative energy block.
module tb_seam_cumulative_energy;
	import sce_pkg::*;

	// The line buffer depth that the block is built with here.
	localparam int MAX_W = 2048;
	localparam int RESET_CYCLES = 6;
	// Idle margin before a width write and, scaled up, at the end of the run.
	localparam int DRAIN_CYCLES = 4;
	// Number of random pixels in the mixed phases.
	localparam int unsigned RANDOM_PIXELS = 1880;
	// The long receiver hold-off that makes the block back up into its input.
	localparam int HOLD_CYCLES = 300;
	// Cycles without any transaction on any channel before the run is abandoned.
	localparam int STALL_LIMIT = 3000;
	localparam int DIRECTED_ROWS = 24;
	localparam int REPORT_LIMIT = 100;

	typedef enum bit {
		STEP_PIXEL,
		STEP_WIDTH
	} step_kind_t;

	// One row of the directed table. A pinned row carries its expected result;
	// every other pixel row is checked against the predictor.
	typedef struct packed {
		step_kind_t               kind;
		logic [ENERGY_W-1:0]      energy;
		logic                     start;
		logic                     pinned;
		logic [RESULT_W-1:0]      want_sum;
		logic                     want_last;
		logic [IMAGE_WIDTH_W-1:0] width;
	} stim_row_t;

	typedef struct packed {
		logic [RESULT_W-1:0] cumulative_energy;
		logic                row_last;
	} seam_result_t;

	logic clk = 1'b0;
	logic arst_n;

	sce_pix_if pix_ch ();
	sce_res_if res_ch ();
	sce_cfg_if cfg_ch ();

	seam_cumulative_energy #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel_in(pix_ch),
		.seam_out(res_ch),
		.cfg     (cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor state: a private copy of the previous row, the held upper-left
	// value, the column tracker and the width register.
	// ------------------------------------------------------------------------
	bit [RESULT_W-1:0]      prev_row [MAX_W];
	bit                     prev_row_known [MAX_W];
	bit [RESULT_W-1:0]      upper_left_hold;
	int unsigned            column;
	bit                     first_row;
	bit [IMAGE_WIDTH_W-1:0] width_reg;

	// Expected results in the order that their pixels were accepted.
	seam_result_t pending_sums [$];

	int unsigned fail_count = 0;
	int unsigned directed_pixels = 0;
	int unsigned random_pixels = 0;
	int unsigned width_writes = 0;
	int unsigned saturated_sums = 0;
	int unsigned results_checked = 0;

	// Shared between the stimulus and the result sink. The sink alone clears
	// the hold request once it has started counting the hold-off.
	bit calm = 1'b0;
	bit hold_request = 1'b0;

	// A width of zero acts as one, and anything past the buffer depth acts as
	// the full depth.
	function automatic int unsigned active_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_W)
			return MAX_W;
		return int'(width_reg);
	endfunction

	// Advances the predictor by one accepted pixel and returns its result.
	function automatic seam_result_t accumulate_seam(input logic [ENERGY_W-1:0] energy,
			input logic start);
		int unsigned w;
		int unsigned c;
		bit [RESULT_W-1:0] upper;
		bit [RESULT_W-1:0] best;
		bit [RESULT_W:0] total;
		seam_result_t outcome;
		w = active_width();
		// A frame start always restarts the image. Otherwise a column that
		// has run past a narrowed width wraps into a new row, which also ends
		// the first row of the image.
		if (start) begin
			column = 0;
			first_row = 1'b1;
		end else if (column >= w) begin
			column = 0;
			first_row = 1'b0;
		end
		c = column;
		upper = prev_row[c];
		if (first_row) begin
			outcome.cumulative_energy = RESULT_W'(energy);
		end else begin
			// The upper-left value was overwritten one pixel ago, so it comes
			// from the held copy; border neighbours are simply left out.
			best = upper;
			if (c > 0 && upper_left_hold < best)
				best = upper_left_hold;
			if (c + 1 < w && prev_row[c + 1] < best)
				best = prev_row[c + 1];
			total = (RESULT_W + 1)'(energy) + (RESULT_W + 1)'(best);
			if (total[RESULT_W]) begin
				outcome.cumulative_energy = SAT_VALUE;
				saturated_sums++;
			end else begin
				outcome.cumulative_energy = total[RESULT_W-1:0];
			end
		end
		upper_left_hold = upper;
		prev_row[c] = outcome.cumulative_energy;
		prev_row_known[c] = 1'b1;
		outcome.row_last = (c + 1 == w);
		if (outcome.row_last) begin
			column = 0;
			first_row = 1'b0;
		end else begin
			column = c + 1;
		end
		return outcome;
	endfunction

	// True when a pixel without a frame start would land in a later row and
	// read a line buffer entry that no pixel has written yet. The stimulus
	// turns such a pixel into a frame start, since that read is undefined.
	function automatic bit reads_unwritten(input logic start);
		int unsigned w;
		int unsigned c;
		bit later_row;
		if (start)
			return 1'b0;
		w = active_width();
		c = column;
		later_row = !first_row;
		if (c >= w) begin
			c = 0;
			later_row = 1'b1;
		end
		if (!later_row)
			return 1'b0;
		return !prev_row_known[c] || (c + 1 < w && !prev_row_known[c + 1]);
	endfunction

	// Idle lengths for both sides: mostly none, often short, rarely long.
	function automatic int unsigned idle_len();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Energies lean on zero, full scale and small values, the rest uniform.
	function automatic logic [ENERGY_W-1:0] pick_energy();
		case ($urandom_range(9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return ENERGY_W'($urandom_range(15));
			end
			default: begin
				return ENERGY_W'($urandom());
			end
		endcase
	endfunction

	// Offers one pixel, waits for its transaction, then records what the
	// block must return for it. valid stays high when the next pixel follows
	// at once, so it is assigned only once per time step.
	task automatic send_pixel(input logic [ENERGY_W-1:0] energy, input logic start,
			input logic pinned, input logic [RESULT_W-1:0] want_sum, input logic want_last);
		seam_result_t predicted;
		int unsigned gap;
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_energy <= energy;
		pix_ch.frame_start <= start;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		predicted = accumulate_seam(energy, start);
		if (pinned)
			pending_sums.push_back('{want_sum, want_last});
		else
			pending_sums.push_back(predicted);
		gap = idle_len();
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The width register is written only once the block has drained.
	task automatic set_width(input logic [IMAGE_WIDTH_W-1:0] w);
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.image_width <= w;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		width_reg = w;
		width_writes++;
	endtask

	// One random phase at a given width. A fresh phase opens a new image;
	// otherwise it carries on from wherever the previous phase left the
	// column, which exercises the wrap after a narrowed width. Noisy phases
	// add a partial row and scatter frame starts through the rows. The run
	// stops sending once the random pixel budget is spent.
	task automatic run_phase(input logic [IMAGE_WIDTH_W-1:0] w, input int unsigned rows,
			input bit fresh, input bit noisy, input bit squeeze);
		int unsigned count;
		logic start;
		set_width(w);
		count = rows * active_width();
		if (noisy && active_width() > 1)
			count += $urandom_range(active_width() - 1);
		// The hold-off starts with the phase so that the sender keeps
		// offering pixels while the result side refuses them.
		if (squeeze)
			hold_request = 1'b1;
		for (int unsigned k = 0; k < count && random_pixels < RANDOM_PIXELS; k++) begin
			start = (k == 0 && fresh) || (noisy && $urandom_range(99) < 4);
			if (reads_unwritten(start))
				start = 1'b1;
			send_pixel(pick_energy(), start, 1'b0, '0, 1'b0);
			random_pixels++;
		end
	endtask

	// Directed rows. The first three run at the reset width. Narrowing the
	// width to three then leaves the column past the end, so the next pixel
	// wraps into a later row. Further rows cover a frame start both at a row
	// boundary and in the middle of a row, a width of zero, and a width past
	// the buffer depth followed by a narrowing that wraps again.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{STEP_PIXEL, 16'hFFFF, 1'b1, 1'b1, 32'h0000_FFFF, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h1234, 1'b0, 1'b1, 32'h0000_1234, 1'b0, 12'd0},
		'{STEP_WIDTH, 16'h0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd3},
		'{STEP_PIXEL, 16'h0001, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'hFFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h8000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h0FFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h0002, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h0003, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h0005, 1'b1, 1'b1, 32'h0000_0005, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h0007, 1'b0, 1'b1, 32'h0000_0007, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h0009, 1'b1, 1'b1, 32'h0000_0009, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h000A, 1'b0, 1'b1, 32'h0000_000A, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h000B, 1'b0, 1'b1, 32'h0000_000B, 1'b1, 12'd0},
		'{STEP_WIDTH, 16'h0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h0004, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h0006, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_WIDTH, 16'h0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd4095},
		'{STEP_PIXEL, 16'hFFFF, 1'b1, 1'b1, 32'h0000_FFFF, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'h0001, 1'b0, 1'b1, 32'h0000_0001, 1'b0, 12'd0},
		'{STEP_WIDTH, 16'h0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd2},
		'{STEP_PIXEL, 16'h0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0},
		'{STEP_PIXEL, 16'hFFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 12'd0}
	};

	// ------------------------------------------------------------------------
	// Result sink: checks every result transaction against the oldest
	// expectation and decides ready for the next cycle. All sampling happens
	// at the rising edge, before the block's registers update.
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int unsigned stall_left;
		seam_result_t want;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (pending_sums.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$error("result with no pixel waiting: cumulative_energy %h row_last %b",
							res_ch.cumulative_energy, res_ch.row_last);
				end else begin
					want = pending_sums.pop_front();
					results_checked++;
					if (res_ch.cumulative_energy !== want.cumulative_energy) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$error("cumulative_energy: expected %h, got %h",
								want.cumulative_energy, res_ch.cumulative_energy);
					end
					if (res_ch.row_last !== want.row_last) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$error("row_last: expected %b, got %b",
								want.row_last, res_ch.row_last);
					end
				end
			end
			// The long hold-off is counted here, cycle by cycle, so that the
			// sender can keep pushing until the block stops taking pixels.
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left == 0)
				stall_left = idle_len();
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: any transaction on any channel counts as progress.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$error("no transaction for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus: reset, the directed table, then random phases.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [IMAGE_WIDTH_W-1:0] w;
		int unsigned rows;
		int unsigned r;
		int unsigned phase_count;
		bit fresh;
		bit noisy;
		bit squeeze;
		bit big_done;

		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_energy = '0;
		pix_ch.frame_start = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.image_width = '0;

		// Predictor state after reset. The line buffer content is unknown
		// to the block, so every entry starts out as never written.
		foreach (prev_row[i]) begin
			prev_row[i] = '0;
			prev_row_known[i] = 1'b0;
		end
		upper_left_hold = '0;
		column = 0;
		first_row = 1'b1;
		width_reg = IMAGE_WIDTH_RESET;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].kind == STEP_WIDTH) begin
				set_width(directed_rows[i].width);
			end else begin
				send_pixel(directed_rows[i].energy, directed_rows[i].start,
					directed_rows[i].pinned, directed_rows[i].want_sum,
					directed_rows[i].want_last);
				directed_pixels++;
			end
		end

		// Mostly narrow images so that many rows, borders and wraps occur;
		// one row wider than 1024 pixels reaches the top column bit.
		phase_count = 0;
		big_done = 1'b0;
		while (random_pixels < RANDOM_PIXELS) begin
			squeeze = 1'b0;
			if (phase_count == 2) begin
				w = 12'd16;
				rows = 6;
				fresh = 1'b1;
				noisy = 1'b0;
				squeeze = 1'b1;
				calm = 1'b0;
			end else if (!big_done && random_pixels > 400) begin
				w = IMAGE_WIDTH_W'($urandom_range(1100, 1025));
				rows = 1;
				fresh = 1'b1;
				noisy = 1'b0;
				big_done = 1'b1;
				calm = 1'b0;
			end else begin
				r = $urandom_range(99);
				if (r < 8)
					w = 12'd0;
				else if (r < 16)
					w = 12'd1;
				else if (r < 24)
					w = 12'd2;
				else
					w = IMAGE_WIDTH_W'($urandom_range(40, 3));
				rows = $urandom_range(6, 1);
				fresh = $urandom_range(99) < 70;
				noisy = $urandom_range(99) < 30;
				// Some phases run with no idling on either side at all.
				calm = $urandom_range(99) < 15;
			end
			run_phase(w, rows, fresh, noisy, squeeze);
			phase_count++;
		end

		pix_ch.valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES * 4) @(posedge clk);

		$display("Covered %0d directed and %0d random pixels over %0d width writes.",
			directed_pixels, random_pixels, width_writes);
		$display("Checked %0d results, %0d of them clamped at the maximum; %0d mismatches.",
			results_checked, saturated_sums, fail_count);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
